// ----- src/bgm_pkg.sv -----
// Shared constants, register codes and types of the box gradient block.
package bgm_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 1024;
    localparam int MAX_APERTURE_DEF = 7;

    localparam int AP_W   = 3;
    localparam int DIM_W  = 11;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 8;
    localparam int POS_W  = 10;

    // row slot of the line store, wide enough for the largest aperture range
    localparam int SLOT_W = 5;
    // window length 2A+1 and the read step counter over both window passes
    localparam int N_W    = 4;
    localparam int K_W    = 5;
    // signed window difference and its magnitude (255 * 15 fits in 12 bits)
    localparam int SUM_W  = 13;
    localparam int MAG_W  = 12;
    localparam int CNT_W  = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [IDX_W-1:0] REG_APERTURE     = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic ACT_PIXEL = 1'b0;

    localparam logic [AP_W-1:0]  APERTURE_RST = 3'd1;
    localparam logic [DIM_W-1:0] WIDTH_RST    = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST   = 11'd480;

    typedef struct packed {
        logic [AP_W-1:0]  aperture;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              interior;
    } task_t;

endpackage

// ----- src/bgm_line_store.sv -----
// Pixel line store: one write port, two registered read ports.
module bgm_line_store #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [bgm_pkg::PIX_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]         rd_addr0,
    input  logic [ADDR_W-1:0]         rd_addr1,
    output logic [bgm_pkg::PIX_W-1:0] rd_data0,
    output logic [bgm_pkg::PIX_W-1:0] rd_data1
);

    logic [bgm_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

// ----- src/bgm_queue.sv -----
// Two-entry task queue between the front and the back.
module bgm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bgm_pkg::task_t push_task,
    input  logic           pop,
    output bgm_pkg::task_t head,
    output logic           full,
    output logic           empty
);

    bgm_pkg::task_t                  ent_reg [bgm_pkg::QUEUE_DEPTH];
    logic [bgm_pkg::QPTR_W-1:0]      wptr_reg, wptr_next;
    logic [bgm_pkg::QPTR_W-1:0]      rptr_reg, rptr_next;
    logic [bgm_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    assign full  = (cnt_reg == bgm_pkg::QCNT_W'(bgm_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = ent_reg[rptr_reg];

    always_comb begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wptr_reg] <= push_task;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue pop while empty");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= bgm_pkg::QCNT_W'(bgm_pkg::QUEUE_DEPTH)) else $error("queue count overrun");
`endif

endmodule

// ----- src/bgm_front.sv -----
// Front: configuration, input counters, line store writes and result scheduling.
module bgm_front #(
    parameter int MAX_WIDTH    = bgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = bgm_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_APERTURE = bgm_pkg::MAX_APERTURE_DEF,
    parameter int ADDR_W       = 14
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [bgm_pkg::IDX_W-1:0] cfg_index,
    input  logic [bgm_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [bgm_pkg::PIX_W-1:0] s_pixel,
    input  logic                      q_full,
    output logic                      push,
    output bgm_pkg::task_t            push_task,
    output bgm_pkg::cfg_t             cfg,
    output logic                      wr_en,
    output logic [ADDR_W-1:0]         wr_addr,
    output logic [bgm_pkg::PIX_W-1:0] wr_data
);

    localparam int ROWS  = 2 * MAX_APERTURE + 2;
    localparam int LAG_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DLY_W = bgm_pkg::AP_W + bgm_pkg::DIM_W + 1;
    localparam int CMP_W = (LAG_W > DLY_W) ? LAG_W : DLY_W;
    localparam int DW    = bgm_pkg::DIM_W;
    localparam int SW    = bgm_pkg::SLOT_W;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v, input int lim);
        logic [DW-1:0] r;
        if (v == '0) begin
            r = DW'(1);
        end else if (32'(v) > lim) begin
            r = DW'(lim);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [bgm_pkg::AP_W-1:0] clamp_ap(input logic [bgm_pkg::AP_W-1:0] v);
        logic [bgm_pkg::AP_W-1:0] r;
        if (32'(v) > MAX_APERTURE) begin
            r = bgm_pkg::AP_W'(MAX_APERTURE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(ROWS - 1)) ? '0 : s + 1'b1;
    endfunction

    logic [bgm_pkg::AP_W-1:0] ap_reg, ap_next;
    logic [DW-1:0]            w_reg, w_next;
    logic [DW-1:0]            h_reg, h_next;
    logic [DW-1:0]            in_row_reg, in_row_next;
    logic [DW-1:0]            in_col_reg, in_col_next;
    logic [SW-1:0]            in_slot_reg, in_slot_next;
    logic [DW-1:0]            out_row_reg, out_row_next;
    logic [DW-1:0]            out_col_reg, out_col_next;
    logic [SW-1:0]            out_slot_reg, out_slot_next;
    logic [LAG_W-1:0]         lag_reg, lag_next;
    logic                     full_reg, full_next;
    logic [DLY_W-1:0]         delay;
    logic                     accept, emit, restart, interior;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign cfg     = '{aperture: ap_reg, width: w_reg, height: h_reg};
    assign delay   = DLY_W'(ap_reg) * DLY_W'(w_reg) + DLY_W'(ap_reg);

    assign interior = (out_row_reg >= DW'(ap_reg))
                   && ((DW + 1)'(out_row_reg) + (DW + 1)'(ap_reg) < (DW + 1)'(h_reg))
                   && (out_col_reg >= DW'(ap_reg))
                   && ((DW + 1)'(out_col_reg) + (DW + 1)'(ap_reg) < (DW + 1)'(w_reg));

    assign push_task = '{row: out_row_reg, col: out_col_reg, slot: out_slot_reg,
                         interior: interior};
    assign wr_addr   = ADDR_W'(ADDR_W'(in_slot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_reg));
    assign wr_data   = s_pixel;

    always_comb begin
        ap_next       = ap_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        lag_next      = lag_reg;
        full_next     = full_reg;
        wr_en         = 1'b0;
        emit          = 1'b0;
        restart       = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index)
                bgm_pkg::REG_APERTURE: begin
                    ap_next = clamp_ap(cfg_data[bgm_pkg::AP_W-1:0]);
                    restart = 1'b1;
                end
                bgm_pkg::REG_IMAGE_WIDTH: begin
                    w_next  = clamp_dim(cfg_data[DW-1:0], MAX_WIDTH);
                    restart = 1'b1;
                end
                bgm_pkg::REG_IMAGE_HEIGHT: begin
                    h_next  = clamp_dim(cfg_data[DW-1:0], MAX_HEIGHT);
                    restart = 1'b1;
                end
                default: ;
            endcase
        end else if (accept) begin
            if (s_action == bgm_pkg::ACT_PIXEL && !full_reg) begin
                wr_en    = 1'b1;
                lag_next = lag_reg + 1'b1;
                if ((DW + 1)'(in_col_reg) + 1'b1 >= (DW + 1)'(w_reg)) begin
                    in_col_next = '0;
                    if ((DW + 1)'(in_row_reg) + 1'b1 >= (DW + 1)'(h_reg)) begin
                        in_row_next  = '0;
                        in_slot_next = '0;
                        full_next    = 1'b1;
                    end else begin
                        in_row_next  = in_row_reg + 1'b1;
                        in_slot_next = slot_inc(in_slot_reg);
                    end
                end else begin
                    in_col_next = in_col_reg + 1'b1;
                end
                emit = CMP_W'(lag_next) > CMP_W'(delay);
            end else if (full_reg) begin
                emit = 1'b1;
            end
            if (emit) begin
                lag_next = lag_next - 1'b1;
                if ((DW + 1)'(out_col_reg) + 1'b1 >= (DW + 1)'(w_reg)) begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + 1'b1;
                    out_slot_next = slot_inc(out_slot_reg);
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
                // last result of a full frame: start over
                if (full_next && out_row_next >= h_reg) begin
                    restart = 1'b1;
                end
            end
        end
        if (restart) begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_slot_next  = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_slot_next = '0;
            lag_next      = '0;
            full_next     = 1'b0;
        end
    end

    assign push = emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ap_reg       <= clamp_ap(bgm_pkg::APERTURE_RST);
            w_reg        <= clamp_dim(bgm_pkg::WIDTH_RST, MAX_WIDTH);
            h_reg        <= clamp_dim(bgm_pkg::HEIGHT_RST, MAX_HEIGHT);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            lag_reg      <= '0;
            full_reg     <= 1'b0;
        end else begin
            ap_reg       <= ap_next;
            w_reg        <= w_next;
            h_reg        <= h_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            lag_reg      <= lag_next;
            full_reg     <= full_next;
        end
    end

endmodule

// ----- src/bgm_back.sv -----
// Back: window reads, shared serial divider and output register.
module bgm_back #(
    parameter int MAX_WIDTH    = bgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_APERTURE = bgm_pkg::MAX_APERTURE_DEF,
    parameter int ADDR_W       = 14
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bgm_pkg::cfg_t              cfg,
    input  logic                       q_empty,
    input  bgm_pkg::task_t             q_head,
    output logic                       q_pop,
    output logic [ADDR_W-1:0]          rd_addr0,
    output logic [ADDR_W-1:0]          rd_addr1,
    input  logic [bgm_pkg::PIX_W-1:0]  rd_data0,
    input  logic [bgm_pkg::PIX_W-1:0]  rd_data1,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [bgm_pkg::GRAD_W-1:0] m_grad_x,
    output logic [bgm_pkg::GRAD_W-1:0] m_grad_y,
    output logic [bgm_pkg::POS_W-1:0]  m_out_row,
    output logic [bgm_pkg::POS_W-1:0]  m_out_col
);

    localparam int ROWS = 2 * MAX_APERTURE + 2;
    localparam int SW   = bgm_pkg::SLOT_W;
    localparam int DW   = bgm_pkg::DIM_W;
    localparam int NW   = bgm_pkg::N_W;
    localparam int MW   = bgm_pkg::MAG_W;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DIV, ST_OUT} state_t;

    state_t                        state_reg;
    logic [DW-1:0]                 row_reg, col_reg;
    logic [SW-1:0]                 slotp_reg, slotm_reg, rslot_reg;
    logic [DW-1:0]                 colk_reg, colp_reg, colm_reg;
    logic [bgm_pkg::K_W-1:0]       k_reg;
    logic                          pend_reg, pend_ph_reg;
    logic signed [bgm_pkg::SUM_W-1:0] sx_reg, sy_reg;
    logic [NW-1:0]                 rem_reg;
    logic [MW-1:0]                 quo_reg;
    logic [bgm_pkg::CNT_W-1:0]     cnt_reg;
    logic                          sel_reg;
    logic [bgm_pkg::GRAD_W-1:0]    gx_reg, gy_reg;
    logic                          m_valid_reg;
    logic [bgm_pkg::GRAD_W-1:0]    m_gx_reg, m_gy_reg;
    logic [bgm_pkg::POS_W-1:0]     m_row_reg, m_col_reg;

    logic [NW-1:0]                 n;
    logic [bgm_pkg::K_W-1:0]       two_n;
    logic                          phase2;
    logic [SW-1:0]                 rs0, rs1;
    logic [DW-1:0]                 rc0, rc1;
    logic signed [bgm_pkg::SUM_W-1:0] diff;
    logic [SW:0]                   sp_sum, sm_sum;
    logic [NW:0]                   shifted;
    logic [MW-1:0]                 quo_next;
    logic [NW-1:0]                 rem_next;
    logic [MW-1:0]                 mag_x, mag_y;
    logic signed [bgm_pkg::SUM_W-1:0] ax, ay;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(ROWS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign n      = {cfg.aperture, 1'b1};
    assign two_n  = {n, 1'b0};
    assign phase2 = (k_reg >= bgm_pkg::K_W'(n));

    // row pass reads rows a+A and a-A; column pass reads columns b+A and b-A
    assign rs0 = phase2 ? rslot_reg : slotp_reg;
    assign rs1 = phase2 ? rslot_reg : slotm_reg;
    assign rc0 = phase2 ? colp_reg : colk_reg;
    assign rc1 = phase2 ? colm_reg : colk_reg;
    assign rd_addr0 = ADDR_W'(ADDR_W'(rs0) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rc0));
    assign rd_addr1 = ADDR_W'(ADDR_W'(rs1) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rc1));

    assign diff = bgm_pkg::SUM_W'($signed({1'b0, rd_data0}))
                - bgm_pkg::SUM_W'($signed({1'b0, rd_data1}));

    assign sp_sum = (SW + 1)'(q_head.slot) + (SW + 1)'(cfg.aperture);
    assign sm_sum = (q_head.slot >= SW'(cfg.aperture))
                  ? (SW + 1)'(q_head.slot) - (SW + 1)'(cfg.aperture)
                  : (SW + 1)'(q_head.slot) + (SW + 1)'(ROWS) - (SW + 1)'(cfg.aperture);

    assign ax    = (sx_reg < 0) ? -sx_reg : sx_reg;
    assign ay    = (sy_reg < 0) ? -sy_reg : sy_reg;
    assign mag_x = ax[MW-1:0];
    assign mag_y = ay[MW-1:0];

    // one restoring divider step
    assign shifted = {rem_reg, quo_reg[MW-1]};
    always_comb begin
        if (shifted >= (NW + 1)'(n)) begin
            rem_next = NW'(shifted - (NW + 1)'(n));
            quo_next = {quo_reg[MW-2:0], 1'b1};
        end else begin
            rem_next = shifted[NW-1:0];
            quo_next = {quo_reg[MW-2:0], 1'b0};
        end
    end

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign m_valid   = m_valid_reg;
    assign m_grad_x  = m_gx_reg;
    assign m_grad_y  = m_gy_reg;
    assign m_out_row = m_row_reg;
    assign m_out_col = m_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            // drop the word once taken, unless a new one loads this cycle
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        row_reg <= q_head.row;
                        col_reg <= q_head.col;
                        if (q_head.interior) begin
                            slotp_reg <= (sp_sum >= (SW + 1)'(ROWS))
                                       ? SW'(sp_sum - (SW + 1)'(ROWS)) : SW'(sp_sum);
                            slotm_reg <= SW'(sm_sum);
                            rslot_reg <= SW'(sm_sum);
                            colk_reg  <= q_head.col - DW'(cfg.aperture);
                            colp_reg  <= q_head.col + DW'(cfg.aperture);
                            colm_reg  <= q_head.col - DW'(cfg.aperture);
                            k_reg     <= '0;
                            pend_reg  <= 1'b0;
                            sx_reg    <= '0;
                            sy_reg    <= '0;
                            state_reg <= ST_READ;
                        end else begin
                            gx_reg    <= '0;
                            gy_reg    <= '0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_READ: begin
                    // accumulate the pair whose read was issued in the previous cycle
                    if (pend_reg) begin
                        if (pend_ph_reg) begin
                            sy_reg <= sy_reg + diff;
                        end else begin
                            sx_reg <= sx_reg + diff;
                        end
                    end
                    if (k_reg < two_n) begin
                        pend_reg    <= 1'b1;
                        pend_ph_reg <= phase2;
                        k_reg       <= k_reg + 1'b1;
                        if (phase2) begin
                            rslot_reg <= slot_inc(rslot_reg);
                        end else begin
                            colk_reg <= colk_reg + 1'b1;
                        end
                    end else begin
                        pend_reg <= 1'b0;
                        if (!pend_reg) begin
                            quo_reg   <= mag_x;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            sel_reg   <= 1'b0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == bgm_pkg::CNT_W'(MW - 1)) begin
                        if (!sel_reg) begin
                            gx_reg  <= quo_next[bgm_pkg::GRAD_W-1:0];
                            quo_reg <= mag_y;
                            rem_reg <= '0;
                            cnt_reg <= '0;
                            sel_reg <= 1'b1;
                        end else begin
                            gy_reg    <= quo_next[bgm_pkg::GRAD_W-1:0];
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        quo_reg <= quo_next;
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_gx_reg    <= gx_reg;
                        m_gy_reg    <= gy_reg;
                        m_row_reg   <= row_reg[bgm_pkg::POS_W-1:0];
                        m_col_reg   <= col_reg[bgm_pkg::POS_W-1:0];
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (k_reg <= two_n)) else $error("read step overrun");
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (rslot_reg < SW'(ROWS))) else $error("row slot overrun");
`endif

endmodule

// ----- src/box_gradient_magnitude.sv -----
// A border result goes from the queue via ST_IDLE and ST_OUT to the output register;
// an interior one first passes ST_READ (4A+2 line store reads, then a drain) and ST_DIV.
// Throughput: the front takes one word per cycle while its 2-entry queue has room;
// the back pops a result only in ST_IDLE, so it ends one before it takes the next,
// paced by the two-port line store reads and the one-bit-per-cycle divider (2*12 steps).
// Reset: synchronous active-low aresetn restores config defaults and clears counters.
module box_gradient_magnitude #(
    parameter int MAX_WIDTH    = bgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = bgm_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_APERTURE = bgm_pkg::MAX_APERTURE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [bgm_pkg::IDX_W-1:0]  cfg_index,
    input  logic [bgm_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [bgm_pkg::PIX_W-1:0]  s_pixel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [bgm_pkg::GRAD_W-1:0] m_grad_x,
    output logic [bgm_pkg::GRAD_W-1:0] m_grad_y,
    output logic [bgm_pkg::POS_W-1:0]  m_out_row,
    output logic [bgm_pkg::POS_W-1:0]  m_out_col
);

    // line store keeps 2*MAX_APERTURE+2 rows; a row slot picks one of them
    localparam int DEPTH  = (2 * MAX_APERTURE + 2) * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                      push, pop, q_full, q_empty;
    bgm_pkg::task_t            push_task, head;
    bgm_pkg::cfg_t             cfg;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr, rd_addr0, rd_addr1;
    logic [bgm_pkg::PIX_W-1:0] wr_data, rd_data0, rd_data1;

    // front: count words, write pixels, decide which words release a result
    bgm_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_APERTURE (MAX_APERTURE),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_pixel   (s_pixel),
        .q_full    (q_full),
        .push      (push),
        .push_task (push_task),
        .cfg       (cfg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // hold scheduled results until the back is free
    bgm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_task (push_task),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    bgm_line_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    // back: sum window differences, divide by 2A+1, present the word
    bgm_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_APERTURE (MAX_APERTURE),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_head    (head),
        .q_pop     (pop),
        .rd_addr0  (rd_addr0),
        .rd_addr1  (rd_addr1),
        .rd_data0  (rd_data0),
        .rd_data1  (rd_data1),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_grad_x  (m_grad_x),
        .m_grad_y  (m_grad_y),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col)
    );

endmodule
